>>> hdl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 decoder: widths, lead-byte masks and patterns,
// surrogate constants and the result type passed from the decode step to the queue.
// No dependencies.
`default_nettype none

package u8u16_pkg;

  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;
  localparam int ACC_W  = 26;
  localparam int REM_W  = 3;
  localparam int CONT_W = 6;
  localparam int HALF_W = 10;

  // Depth of the result queue; a byte is decoded only when two entries are free.
  localparam int RES_DEPTH_DEF = 4;

  // Lead-byte classification.
  localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
  localparam logic [BYTE_W-1:0] MASK_2B   = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_2B    = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3B   = 8'hF0;
  localparam logic [BYTE_W-1:0] PAT_3B    = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4B   = 8'hF8;
  localparam logic [BYTE_W-1:0] PAT_4B    = 8'hF0;

  // Sequence lengths.
  localparam logic [REM_W-1:0] LEN_2B = 3'd2;
  localparam logic [REM_W-1:0] LEN_3B = 3'd3;
  localparam logic [REM_W-1:0] LEN_4B = 3'd4;
  localparam logic [REM_W-1:0] LEN_5B = 3'd5;

  // Surrogate arithmetic.
  localparam logic [ACC_W-1:0]  SUR_BASE = 26'h001_0000;
  localparam logic [UNIT_W-1:0] SUR_HIGH = 16'hD800;
  localparam logic [UNIT_W-1:0] SUR_LOW  = 16'hDC00;

  // Units produced by one byte.
  typedef enum logic [1:0] {
    UNITS_NONE = 2'd0,
    UNITS_ONE  = 2'd1,
    UNITS_PAIR = 2'd2
  } unit_cnt_t;

  typedef struct packed {
    unit_cnt_t         n_units;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
  } step_res_t;

endpackage

`default_nettype wire

>>> hdl/u8u16_if.sv
// Valid/ready channel interfaces for the decoder's byte input and unit output.
// Depends on u8u16_pkg.
`default_nettype none

interface u8u16_in_if;
  logic                          valid;
  logic                          ready;
  logic [u8u16_pkg::BYTE_W-1:0]  byte_in;
  logic                          end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface u8u16_out_if;
  logic                          valid;
  logic                          ready;
  logic [u8u16_pkg::UNIT_W-1:0]  unit_out;
  logic                          last_unit;

  modport source (output valid, output unit_out, output last_unit, input ready);
  modport sink   (input valid, input unit_out, input last_unit, output ready);
endinterface

`default_nettype wire

>>> hdl/u8u16_step.sv
// Decode step: holds the sequence state and turns one registered byte into
// zero, one or two UTF-16 units. Depends on u8u16_pkg.
`default_nettype none

module u8u16_step (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic [u8u16_pkg::BYTE_W-1:0]  byte_in,
  input  wire logic                          end_of_text,
  output u8u16_pkg::step_res_t               res
);
  import u8u16_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] len_r, len_nxt;

  logic [ACC_W-1:0] acc_shift;
  logic [ACC_W-1:0] h_val;
  logic [REM_W-1:0] rem_dec;

  // Continuation path: shift in six bits and offset for a possible surrogate pair.
  assign acc_shift = {acc_r[ACC_W-CONT_W-1:0], byte_in[CONT_W-1:0]};
  assign rem_dec   = rem_r - 3'd1;
  assign h_val     = acc_shift - SUR_BASE;

  // Next state and units for the byte in the input register.
  always_comb begin
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    len_nxt     = len_r;
    res.n_units = UNITS_NONE;
    res.unit0   = {8'h00, byte_in};
    res.unit1   = {SUR_LOW[UNIT_W-1:HALF_W], h_val[HALF_W-1:0]};
    if (rem_r == '0) begin
      if (byte_in <= ASCII_MAX) begin
        res.n_units = UNITS_ONE;
      end else if ((byte_in & MASK_2B) == PAT_2B) begin
        acc_nxt = {21'b0, byte_in[4:0]};
        rem_nxt = 3'd1;
        len_nxt = LEN_2B;
      end else if ((byte_in & MASK_3B) == PAT_3B) begin
        acc_nxt = {22'b0, byte_in[3:0]};
        rem_nxt = 3'd2;
        len_nxt = LEN_3B;
      end else if ((byte_in & MASK_4B) == PAT_4B) begin
        acc_nxt = {23'b0, byte_in[2:0]};
        rem_nxt = 3'd3;
        len_nxt = LEN_4B;
      end else begin
        acc_nxt = {24'b0, byte_in[1:0]};
        rem_nxt = 3'd4;
        len_nxt = LEN_5B;
      end
    end else begin
      acc_nxt = acc_shift;
      rem_nxt = rem_dec;
      if (rem_dec == '0) begin
        if (len_r <= LEN_3B) begin
          res.n_units = UNITS_ONE;
          res.unit0   = acc_shift[UNIT_W-1:0];
        end else begin
          res.n_units = UNITS_PAIR;
          res.unit0   = h_val[ACC_W-1:HALF_W] + SUR_HIGH;
        end
        acc_nxt = '0;
        len_nxt = '0;
      end
    end
    // The final byte of the text drops any unfinished sequence.
    if (end_of_text) begin
      acc_nxt = '0;
      rem_nxt = '0;
      len_nxt = '0;
    end
  end

  // Sequence state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= '0;
      len_r <= '0;
    end else if (fire) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/u8u16_queue.sv
// Result queue: takes up to two units per cycle from the decode step and
// hands out one unit per output transaction. Depends on u8u16_pkg.
`default_nettype none

module u8u16_queue #(
  parameter int DEPTH = u8u16_pkg::RES_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire u8u16_pkg::step_res_t          res,
  output logic                               room,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [u8u16_pkg::UNIT_W-1:0]       out_unit,
  output logic                               out_last,
  output logic [$clog2(DEPTH+1)-1:0]         level
);
  import u8u16_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

  logic [UNIT_W-1:0] unit_mem [DEPTH];
  logic              last_mem [DEPTH];

  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wptr_1, wptr_2;
  logic [CNT_W-1:0] n_push;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  assign wptr_1 = ptr_inc(wptr_r);
  assign wptr_2 = ptr_inc(wptr_1);

  assign room      = (cnt_r <= ROOM_MAX);
  assign out_valid = (cnt_r != '0);
  assign out_unit  = unit_mem[rptr_r];
  assign out_last  = last_mem[rptr_r];
  assign level     = cnt_r;
  assign pop       = out_valid && out_ready;

  // Pointer and fill-count update.
  always_comb begin
    n_push = '0;
    if (push) begin
      case (res.n_units)
        UNITS_ONE:  n_push = CNT_W'(1);
        UNITS_PAIR: n_push = CNT_W'(2);
        default:    n_push = '0;
      endcase
    end
    case (n_push)
      CNT_W'(1): wptr_nxt = wptr_1;
      CNT_W'(2): wptr_nxt = wptr_2;
      default:   wptr_nxt = wptr_r;
    endcase
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage; a pair takes two consecutive entries.
  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      unit_mem[wptr_r] <= res.unit0;
      last_mem[wptr_r] <= (res.n_units == UNITS_ONE);
    end
    if (n_push == CNT_W'(2)) begin
      unit_mem[wptr_1] <= res.unit1;
      last_mem[wptr_1] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hdl/utf8_to_utf16_decoder.sv
// Path: an accepted byte waits in the input register until the result queue has room
// for a pair; it is then decoded and its units are written into the queue.
// Throughput: one byte per cycle while each byte gives at most one unit and the
// receiver never stalls; a byte that completes a surrogate pair needs two output
// transactions, since the output port moves one unit per transaction and the result
// queue paces input.
// Reset: synchronous, active low; clears the sequence state, input register and queue.
`default_nettype none

module utf8_to_utf16_decoder #(
  parameter int RES_DEPTH = u8u16_pkg::RES_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);
  import u8u16_pkg::*;

  localparam int CNT_W = $clog2(RES_DEPTH+1);

  logic              stg_v_r, stg_v_nxt;
  logic [BYTE_W-1:0] stg_byte_r;
  logic              stg_end_r;
  logic              room;
  logic              fire;
  logic              in_take;
  step_res_t         res;
  logic [CNT_W-1:0]  level;

  // The registered byte is decoded once the queue has room for a pair.
  assign fire         = stg_v_r && room;
  assign in_ch.ready  = !stg_v_r || room;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign stg_v_nxt    = in_take || (stg_v_r && !fire);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r <= in_ch.byte_in;
      stg_end_r  <= in_ch.end_of_text;
    end
  end

  u8u16_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .byte_in     (stg_byte_r),
    .end_of_text (stg_end_r),
    .res         (res)
  );

  u8u16_queue #(
    .DEPTH (RES_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .res       (res),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_unit  (out_ch.unit_out),
    .out_last  (out_ch.last_unit),
    .level     (level)
  );

  // The queue never holds more entries than it has.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= CNT_W'(RES_DEPTH))
    else $error("result queue overfilled");

  // A high surrogate is always followed by its low half.
  a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_unit) |=> out_ch.valid)
    else $error("high surrogate without low surrogate");

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && !stg_v_r))
    else $error("data present after reset");

  // A decoded byte only goes to a queue with room for a pair.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (level <= CNT_W'(RES_DEPTH - 2)))
    else $error("decode without room in queue");

endmodule

`default_nettype wire

>>> tb/sv/tb_utf8_to_utf16_decoder.sv
// Testbench for the UTF-8 to UTF-16 decoder: directed and random byte streams are
// checked against a predictor of the decoder. Depends on u8u16_pkg, the channel
// interfaces in u8u16_if.sv and the decoder RTL.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder;

  import u8u16_pkg::*;

  // Surrogate arithmetic as the decoder defines it.
  localparam logic [31:0] SURR_OFFSET = 32'h0001_0000;
  localparam logic [31:0] HIGH_BASE   = 32'h0000_D800;
  localparam logic [31:0] LOW_BASE    = 32'h0000_DC00;
  localparam int          HALF_BITS   = 10;

  // Run length guard: far beyond the slowest correct run.
  localparam time RUN_LIMIT = 10_000_000;
  localparam int  HOLD_LEN  = 80;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              is_last;
  } unit_t;

  logic clk = 1'b0;
  logic rst_n;

  u8u16_in_if  in_ch();
  u8u16_out_if out_ch();

  utf8_to_utf16_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: payload bits, bytes still awaited and length of the sequence.
  logic [ACC_W-1:0] acc_bits;
  logic [2:0]       bytes_left;
  logic [2:0]       seq_len;

  unit_t expected_units[$];
  int    errors     = 0;
  int    bytes_sent = 0;

  // Idling controls shared between the sender, the receiver and the tests.
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  int hold_req  = 0;
  int hold_left = 0;
  int stall_left = 0;

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length in cycles: mostly short, now and then long.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    else if (r < 92) return $urandom_range(3, 6);
    else return $urandom_range(10, 30);
  endfunction

  // Works out the code units that one accepted byte produces and queues them.
  task automatic transcode_byte(input logic [7:0] b, input logic eot);
    logic [31:0] h;
    logic [31:0] hi32;
    logic [31:0] lo32;
    unit_t       u;
    if (bytes_left == 3'd0) begin
      casez (b)
        8'b0???????: begin
          u.code_unit = {8'h00, b};
          u.is_last   = 1'b1;
          expected_units = {expected_units, u};
        end
        8'b110?????: begin
          acc_bits   = {21'd0, b[4:0]};
          bytes_left = 3'd1;
          seq_len    = 3'd2;
        end
        8'b1110????: begin
          acc_bits   = {22'd0, b[3:0]};
          bytes_left = 3'd2;
          seq_len    = 3'd3;
        end
        8'b11110???: begin
          acc_bits   = {23'd0, b[2:0]};
          bytes_left = 3'd3;
          seq_len    = 3'd4;
        end
        default: begin
          // Stray continuation bytes and 11111xxx start the five-byte form.
          acc_bits   = {24'd0, b[1:0]};
          bytes_left = 3'd4;
          seq_len    = 3'd5;
        end
      endcase
    end else begin
      acc_bits   = {acc_bits[ACC_W-7:0], b[5:0]};
      bytes_left = bytes_left - 3'd1;
      if (bytes_left == 3'd0) begin
        if (seq_len <= 3'd3) begin
          u.code_unit = acc_bits[UNIT_W-1:0];
          u.is_last   = 1'b1;
          expected_units = {expected_units, u};
        end else begin
          // Values below the offset wrap; both halves are cut to 16 bits.
          h    = {6'd0, acc_bits} - SURR_OFFSET;
          hi32 = (h >> HALF_BITS) + HIGH_BASE;
          lo32 = {22'd0, h[HALF_BITS-1:0]} + LOW_BASE;
          u.code_unit = hi32[UNIT_W-1:0];
          u.is_last   = 1'b0;
          expected_units = {expected_units, u};
          u.code_unit = lo32[UNIT_W-1:0];
          u.is_last   = 1'b1;
          expected_units = {expected_units, u};
        end
        acc_bits = '0;
        seq_len  = 3'd0;
      end
    end
    // End of text drops any unfinished sequence.
    if (eot) begin
      acc_bits   = '0;
      bytes_left = 3'd0;
      seq_len    = 3'd0;
    end
  endtask

  // Offers one byte, waits for its transaction and records the expected units.
  task automatic send_byte(input logic [7:0] b, input logic eot = 1'b0);
    int gap;
    gap = (src_gaps && $urandom_range(0, 99) < 30) ? rand_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.byte_in     = b;
    in_ch.end_of_text = eot;
    do @(posedge clk); while (!in_ch.ready);
    transcode_byte(b, eot);
    bytes_sent++;
  endtask

  // Lead byte for a sequence of the given length, with random payload bits.
  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      1: return 8'($urandom_range(0, 8'h7F));
      2: return 8'hC0 | 8'($urandom_range(0, 31));
      3: return 8'hE0 | 8'($urandom_range(0, 15));
      4: return 8'hF0 | 8'($urandom_range(0, 7));
      default: return $urandom_range(0, 1) ? (8'h80 | 8'($urandom_range(0, 63)))
                                           : (8'hF8 | 8'($urandom_range(0, 7)));
    endcase
  endfunction

  // Continuation byte: usually well formed, sometimes any byte at all.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Sends one character, now and then cut short or closed by an end of text.
  task automatic send_char();
    int  len;
    int  cnt;
    int  r;
    r   = $urandom_range(0, 99);
    len = (r < 30) ? 1 : (r < 50) ? 2 : (r < 70) ? 3 : (r < 88) ? 4 : 5;
    cnt = len;
    if (len > 1 && $urandom_range(0, 19) == 0) cnt = $urandom_range(1, len - 1);
    for (int i = 0; i < cnt; i++) begin
      if (i == 0) send_byte(lead_byte(len), (cnt == 1 && cnt < len) ? 1'b1 : 1'b0);
      else send_byte(cont_byte(),
                     (i == cnt - 1) && (cnt < len || $urandom_range(0, 29) == 0));
    end
  endtask

  // Noise: a random byte with a random end flag.
  task automatic send_noise();
    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  // Random text until the byte count reaches the target.
  task automatic send_text(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_char();
    end
  endtask

  // ASCII extremes pass straight through.
  task automatic test_ascii();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h41);
  endtask

  // Two- and three-byte sequences, including an overlong zero and the maxima.
  task automatic test_bmp();
    send_byte(8'hC0); send_byte(8'h80);
    send_byte(8'hDF); send_byte(8'hBF);
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
    send_byte(8'hEF); send_byte(8'hFF); send_byte(8'hFF);
  endtask

  // Four-byte sequences, one of them below the offset so that it wraps.
  task automatic test_surrogates();
    send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
    send_byte(8'hF0); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
  endtask

  // Five-byte forms led by a stray continuation byte and by 0xFF.
  task automatic test_five_byte();
    send_byte(8'h80);
    repeat (4) send_byte(8'h80);
    send_byte(8'hFF);
    repeat (4) send_byte(8'hFF);
  endtask

  // End of text: an unfinished sequence is dropped, a finished one still emits.
  task automatic test_end_of_text();
    send_byte(8'hE2); send_byte(8'h82, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hC3); send_byte(8'hA9, 1'b1);
    send_byte(8'h5A, 1'b1);
  endtask

  // Random text with idling on both sides.
  task automatic test_random_text();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    send_text(800);
  endtask

  // Random text at full rate with no idling anywhere.
  task automatic test_full_rate();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_text(250);
    sink_gaps = 1'b1;
    src_gaps  = 1'b1;
  endtask

  // The receiver holds off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    src_gaps = 1'b0;
    hold_req = HOLD_LEN;
    send_text(200);
    src_gaps = 1'b1;
  endtask

  // Receiver: random stalls, plus the long hold when one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (sink_gaps && $urandom_range(0, 99) < 25) begin
        out_ch.ready = 1'b0;
        stall_left   = rand_gap() - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Each output transaction is compared with the oldest expected unit.
  always @(posedge clk) begin
    unit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_units.size() == 0) begin
        $error("unit_out: no unit expected, got %h", out_ch.unit_out);
        errors++;
      end else begin
        want = expected_units.pop_front();
        if (out_ch.unit_out !== want.code_unit) begin
          $error("unit_out: expected %h, actual %h", want.code_unit, out_ch.unit_out);
          errors++;
        end
        if (out_ch.last_unit !== want.is_last) begin
          $error("last_unit: expected %b, actual %b", want.is_last, out_ch.last_unit);
          errors++;
        end
      end
    end
  end

  // Sequence of tests.
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.byte_in     = '0;
    in_ch.end_of_text = 1'b0;
    acc_bits          = '0;
    bytes_left        = 3'd0;
    seq_len           = 3'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ascii();
    test_bmp();
    test_surrogates();
    test_five_byte();
    test_end_of_text();
    test_random_text();
    test_full_rate();
    test_backpressure();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #RUN_LIMIT;
    $error("timeout with %0d units outstanding", expected_units.size());
    $display("Verification failed");
    $finish;
  end

endmodule
